/* hw/rtl/orb_pkg.sv */
// ----------------------------------------------------------------------------
// orb_pkg
// shared types, constants and arithmetic helpers of the orbit camera update
// ----------------------------------------------------------------------------
package orb_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int QDEPTH       = 2;
    localparam int QPW          = $clog2(QDEPTH);
    localparam int QCW          = $clog2(QDEPTH + 1);
    localparam int DIV_BITS     = 62;
    localparam int DCW          = $clog2(DIV_BITS);
    localparam int SQRT_STEPS   = 32;
    localparam int SCW          = $clog2(SQRT_STEPS);

    localparam int EPS_RAW = (2 ** FRAC_BITS + 500) / 1000;
    localparam logic [30:0] DIST_EPS   = (EPS_RAW > 0) ? 31'(EPS_RAW) : 31'd1;
    localparam logic [30:0] DIST_MAX   = 31'h7FFF_FFFF;
    localparam logic [30:0] DIST_RESET = 31'(15 << FRAC_BITS);
    localparam logic [15:0] ANG_RESET  = 16'd8192;
    localparam logic signed [18:0] HALF_TURN = 19'sd32768;
    localparam logic signed [33:0] GAIN_Q30  = 34'sd652032874;
    localparam logic [61:0] TESS_NUM = 62'(14400) << FRAC_BITS;
    localparam logic [11:0] RES_MAX  = 12'd4095;
    localparam logic [4:0]  CORD_LAST = 5'(CORDIC_STEPS - 1);

    localparam logic [31:0] ATAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef enum logic {
        OP_ROT = 1'b0,
        OP_PAN = 1'b1
    } t_op;

    typedef struct packed {
        logic               req_type;
        logic signed [23:0] delta_dist;
        logic signed [15:0] delta_polar;
        logic signed [15:0] delta_azimuth;
        logic signed [23:0] pan_horiz;
        logic signed [23:0] pan_vert;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] cam_pos_x;
        logic signed [31:0] cam_pos_y;
        logic signed [31:0] cam_pos_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic [30:0]        distance_out;
        logic               flipped;
        logic               retessellate;
        logic [11:0]        tess_resolution;
    } t_res_item;

    typedef struct packed {
        t_op                op;
        logic signed [23:0] da;
        logic signed [23:0] db;
        logic signed [15:0] dp;
        logic signed [15:0] dt;
    } t_cmd;

    // q30 shift, rounding half away from zero
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
        logic signed [63:0] bias;
        bias = v[63] ? 64'sd536870911 : 64'sd536870912;
        return (v + bias) >>> 30;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] res;
        if (v > 34'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/orbit_camera_update.sv */
// ----------------------------------------------------------------------------
// orbit_camera_update
// orbit camera around a look-at point: rotate, zoom and pan requests update
// the spherical state and return camera position and tessellation level
//
//  channel  | handshake         | payload
//  ---------+-------------------+----------------------------------
//  request  | push / full       | i_item  (orb_pkg::t_in_item)
//  result   | pop / empty       | o_item  (orb_pkg::t_res_item)
//  config   | i_cfg_we          | i_cfg_wdata (adaptive retess enable)
//
// the bit-serial divider (once per rotate, up to six times per pan), the
// square root unit and the two cordic runs set how long a request takes
// after reset a position pass runs before the first request is served;
// requests still enter the two-entry queue meanwhile
// one request is worked on at a time; a finished result waits in the
// output register while the next request is already being processed
// ----------------------------------------------------------------------------
module orbit_camera_update (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  orb_pkg::t_in_item  i_item,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output orb_pkg::t_res_item o_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);
    import orb_pkg::*;

    logic cmd_valid;
    logic cmd_take;
    t_cmd cmd;

    orb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    orb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .pop         (pop),
        .empty       (empty),
        .o_item      (o_item)
    );

endmodule

/* hw/rtl/orb_front.sv */
// ----------------------------------------------------------------------------
// orb_front
// accepts requests, sorts them into rotate and pan commands, short queue
// ----------------------------------------------------------------------------
module orb_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  orb_pkg::t_in_item i_item,
    output logic             full,
    output logic             o_cmd_valid,
    output orb_pkg::t_cmd    o_cmd,
    input  logic             i_cmd_take
);
    import orb_pkg::*;

    t_cmd             r_mem [QDEPTH];
    logic [QPW-1:0]   r_wp;
    logic [QPW-1:0]   r_rp;
    logic [QCW-1:0]   r_cnt;
    t_cmd             cls;
    logic             wr;
    logic             rd;

    always_comb begin
        cls.op = t_op'(i_item.req_type);
        if (cls.op == OP_PAN) begin
            cls.da = i_item.pan_horiz;
            cls.db = i_item.pan_vert;
            cls.dp = '0;
            cls.dt = '0;
        end else begin
            cls.da = i_item.delta_dist;
            cls.db = '0;
            cls.dp = i_item.delta_polar;
            cls.dt = i_item.delta_azimuth;
        end
    end

    assign full        = (r_cnt == QCW'(QDEPTH));
    assign wr          = push && !full;
    assign rd          = i_cmd_take && (r_cnt != '0);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= cls;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCW'(wr) - QCW'(rd);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCW'(QDEPTH))
        else $error("queue count beyond depth");

    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_take |-> (r_cnt != '0))
        else $error("command taken from empty queue");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp))
        else $error("pointers apart while queue empty");

endmodule

/* hw/rtl/orb_div.sv */
// ----------------------------------------------------------------------------
// orb_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module orb_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [61:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo
);
    import orb_pkg::*;

    logic           r_busy;
    logic           r_done;
    logic [DCW-1:0] r_cnt;
    logic [61:0]    r_num;
    logic [31:0]    r_den;
    logic [31:0]    r_rem;
    logic [31:0]    r_quo;
    logic [32:0]    rem_sh;
    logic [32:0]    diff;
    logic           ge;

    assign rem_sh = {r_rem, r_num[61]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign ge     = (rem_sh >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[60:0], 1'b0};
                r_rem <= ge ? diff[31:0] : rem_sh[31:0];
                r_quo <= {r_quo[30:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCW'(DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

/* hw/rtl/orb_sqrt.sv */
// ----------------------------------------------------------------------------
// orb_sqrt
// integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module orb_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);
    import orb_pkg::*;

    logic           r_busy;
    logic           r_done;
    logic [SCW-1:0] r_cnt;
    logic [63:0]    r_v;
    logic [63:0]    r_r;
    logic [63:0]    r_bit;
    logic [63:0]    trial;

    assign trial  = r_r + r_bit;
    assign o_done = r_done;
    assign o_root = r_r[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_v    <= i_val;
                r_r    <= '0;
                r_bit  <= 64'd1 << 62;
            end else if (r_busy) begin
                if (r_v >= trial) begin
                    r_v <= r_v - trial;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SCW'(SQRT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

/* hw/rtl/orb_back.sv */
// ----------------------------------------------------------------------------
// orb_back
// camera state, update sequencer with shared multiplier, cordic, divider
// and square root, result register
// ----------------------------------------------------------------------------
module orb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_cmd_valid,
    input  orb_pkg::t_cmd     i_cmd,
    output logic              o_cmd_take,
    input  logic              pop,
    output logic              empty,
    output orb_pkg::t_res_item o_item
);
    import orb_pkg::*;

    typedef enum logic [26:0] {
        S_INIT   = 27'h0000001,
        S_IDLE   = 27'h0000002,
        S_ROT    = 27'h0000004,
        S_PDIFF  = 27'h0000008,
        S_PSCALE = 27'h0000010,
        S_PSQ    = 27'h0000020,
        S_PACC   = 27'h0000040,
        S_DMUL   = 27'h0000080,
        S_DV_GO  = 27'h0000100,
        S_DV_W   = 27'h0000200,
        S_SQ_GO  = 27'h0000400,
        S_SQ_W   = 27'h0000800,
        S_PM1    = 27'h0001000,
        S_PM2    = 27'h0002000,
        S_PM3    = 27'h0004000,
        S_PM4    = 27'h0008000,
        S_PM5    = 27'h0010000,
        S_CSET   = 27'h0020000,
        S_CORD   = 27'h0040000,
        S_CSTO   = 27'h0080000,
        S_HMUL   = 27'h0100000,
        S_HRND   = 27'h0200000,
        S_CMUL   = 27'h0400000,
        S_CRND   = 27'h0800000,
        S_CUPD   = 27'h1000000,
        S_TESS   = 27'h2000000,
        S_DONE   = 27'h4000000
    } t_state;

    typedef enum logic [1:0] {
        SQ_LH   = 2'd0,
        SQ_LC   = 2'd1,
        SQ_TESS = 2'd2
    } t_sqsel;

    localparam logic [2:0] DV_TESS = 3'd5;

    t_state             r_state;
    logic [2:0]         r_idx;
    t_sqsel             r_sqsel;
    logic               r_emit;
    logic               r_cfg_en;
    logic signed [23:0] r_da;
    logic signed [23:0] r_db;
    logic signed [15:0] r_dp;
    logic signed [15:0] r_dt;

    logic [30:0]        r_dist;
    logic [15:0]        r_polar;
    logic [15:0]        r_azim;
    logic               r_flag;
    logic signed [31:0] r_look [3];
    logic signed [31:0] r_cam [3];
    logic               r_retess;
    logic [11:0]        r_tess;

    logic signed [32:0] r_c [3];
    logic signed [31:0] r_cs [3];
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic [63:0]        r_sumh;
    logic [31:0]        r_lh;
    logic [31:0]        r_lc;
    logic [31:0]        r_tq;
    logic signed [31:0] r_q [5];
    logic               r_nneg;
    logic signed [33:0] r_cx;
    logic signed [33:0] r_cy;
    logic signed [33:0] r_cz;
    logic [4:0]         r_it;
    logic               r_cflip;
    logic signed [31:0] r_trig [4];
    logic signed [31:0] r_h [2];

    t_res_item          r_out;
    logic               r_out_valid;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;

    logic               div_start;
    logic [61:0]        div_num;
    logic [31:0]        div_den;
    logic               div_done;
    logic [31:0]        div_quo;
    logic signed [63:0] num_s;
    logic signed [63:0] num_abs;

    logic               sq_start;
    logic [63:0]        sq_val;
    logic               sq_done;
    logic [31:0]        sq_root;

    logic signed [31:0] uvec [3];
    logic signed [31:0] vvec [3];

    logic signed [17:0] rot_dp;
    logic [15:0]        rot_dt;
    logic signed [18:0] rot_p;
    logic [15:0]        rot_pn;
    logic               rot_half;
    logic signed [32:0] rot_nd;
    logic [30:0]        rot_dist;

    logic [32:0]        mag [3];
    logic [1:0]         sh_k;
    logic [32:0]        smag [3];

    logic [31:0]        cs_ang;
    logic [31:0]        cs_t;
    logic [31:0]        cs_a;
    logic signed [33:0] cx_s;
    logic signed [33:0] cy_s;
    logic signed [33:0] c_atn;
    logic               pop_ok;
    logic               load;

    assign pop_ok     = pop && r_out_valid;
    assign load       = (r_state == S_DONE) && r_emit && (!r_out_valid || pop);
    assign empty      = !r_out_valid;
    assign o_item     = r_out;
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_PSQ: begin
                mul_a = r_cs[r_idx[1:0]];
                mul_b = r_cs[r_idx[1:0]];
            end
            S_DMUL: begin
                mul_a = (r_idx == 3'd3) ? r_q[1] : r_q[0];
                mul_b = r_cs[2];
            end
            S_PM1: begin
                mul_a = 32'(r_da);
                mul_b = uvec[r_idx[1:0]];
            end
            S_PM2: begin
                mul_a = 32'(r_db);
                mul_b = vvec[r_idx[1:0]];
            end
            S_HMUL: begin
                mul_a = r_idx[0] ? r_trig[1] : r_trig[0];
                mul_b = r_trig[3];
            end
            S_CMUL: begin
                mul_a = $signed({1'b0, r_dist});
                mul_b = (r_idx == 3'd0) ? r_h[0] : (r_idx == 3'd1) ? r_h[1] : r_trig[2];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // pan screen vectors
    always_comb begin
        uvec[0] = r_flag ? r_q[1] : -r_q[1];
        uvec[1] = r_flag ? -r_q[0] : r_q[0];
        uvec[2] = '0;
        vvec[0] = r_flag ? -r_q[2] : r_q[2];
        vvec[1] = r_flag ? -r_q[3] : r_q[3];
        vvec[2] = r_flag ? r_q[4] : -r_q[4];
    end

    // divider operands
    always_comb begin
        case (r_idx)
            3'd0:    num_s = 64'(r_cs[0]) <<< 30;
            3'd1:    num_s = 64'(r_cs[1]) <<< 30;
            3'd2,
            3'd3:    num_s = r_prod;
            3'd4:    num_s = $signed({32'd0, r_lh}) <<< 30;
            default: num_s = $signed({2'b00, TESS_NUM});
        endcase
        num_abs = num_s[63] ? -num_s : num_s;
        div_num = num_abs[61:0];
        if (r_idx <= 3'd1) begin
            div_den = r_lh;
        end else if (r_idx == DV_TESS) begin
            div_den = {1'b0, r_dist};
        end else begin
            div_den = r_lc;
        end
        div_start = (r_state == S_DV_GO);
    end

    always_comb begin
        case (r_sqsel)
            SQ_LH:   sq_val = r_sumh;
            SQ_LC:   sq_val = r_acc;
            default: sq_val = {32'd0, r_tq};
        endcase
        sq_start = (r_state == S_SQ_GO);
    end

    // rotate arithmetic
    always_comb begin
        rot_dp   = r_flag ? -18'(r_dp) : 18'(r_dp);
        rot_dt   = r_flag ? -r_dt : r_dt;
        rot_p    = $signed({3'b000, r_polar}) + 19'(rot_dp);
        rot_half = 1'b0;
        rot_pn   = rot_p[15:0];
        if (rot_p > HALF_TURN) begin
            rot_pn   = 16'(19'sd65536 - rot_p);
            rot_half = 1'b1;
        end else if (rot_p < 19'sd0) begin
            rot_pn   = 16'(-rot_p);
            rot_half = 1'b1;
        end
        rot_nd = $signed({2'b00, r_dist}) + 33'(r_da);
        if (rot_nd < 33'sd0) begin
            rot_dist = DIST_EPS;
        end else if (rot_nd > $signed({2'b00, DIST_MAX})) begin
            rot_dist = DIST_MAX;
        end else begin
            rot_dist = rot_nd[30:0];
        end
    end

    // pan vector scaling
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = r_c[i][32] ? 33'(-r_c[i]) : 33'(r_c[i]);
        end
        if (mag[0][32:31] != '0 || mag[1][32:31] != '0 || mag[2][32:31] != '0) begin
            sh_k = 2'd2;
        end else if (mag[0][30] || mag[1][30] || mag[2][30]) begin
            sh_k = 2'd1;
        end else begin
            sh_k = 2'd0;
        end
        for (int i = 0; i < 3; i++) begin
            smag[i] = mag[i] >> sh_k;
        end
    end

    // cordic
    always_comb begin
        cs_ang = {(r_idx[0] ? r_polar : r_azim), 16'h0000};
        cs_t   = cs_ang + 32'h4000_0000;
        cs_a   = cs_t[31] ? (cs_ang - 32'h8000_0000) : cs_ang;
        cx_s   = r_cx >>> r_it;
        cy_s   = r_cy >>> r_it;
        c_atn  = $signed({2'b00, ATAN_TURN[r_it]});
    end

    orb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    orb_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (sq_val),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_sqsel     <= SQ_LH;
            r_emit      <= 1'b0;
            r_cfg_en    <= 1'b0;
            r_dist      <= DIST_RESET;
            r_polar     <= ANG_RESET;
            r_azim      <= ANG_RESET;
            r_flag      <= 1'b0;
            r_look[0]   <= '0;
            r_look[1]   <= '0;
            r_look[2]   <= '0;
            r_retess    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_en <= i_cfg_wdata;
            end
            r_out_valid <= (r_out_valid && !pop_ok) || load;
            unique case (r_state)
                S_INIT: begin
                    r_emit  <= 1'b0;
                    r_idx   <= '0;
                    r_state <= S_CSET;
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_emit   <= 1'b1;
                        r_da     <= i_cmd.da;
                        r_db     <= i_cmd.db;
                        r_dp     <= i_cmd.dp;
                        r_dt     <= i_cmd.dt;
                        r_retess <= 1'b0;
                        r_state  <= (i_cmd.op == OP_PAN) ? S_PDIFF : S_ROT;
                    end
                end
                S_ROT: begin
                    r_polar  <= rot_pn;
                    r_azim   <= r_azim + rot_dt + (rot_half ? 16'h8000 : 16'h0000);
                    r_flag   <= r_flag ^ rot_half;
                    r_dist   <= rot_dist;
                    r_retess <= r_cfg_en &&
                                (r_dist[30:FRAC_BITS] != rot_dist[30:FRAC_BITS]);
                    r_idx    <= '0;
                    r_state  <= S_CSET;
                end
                S_PDIFF: begin
                    for (int i = 0; i < 3; i++) begin
                        r_c[i] <= 33'(r_look[i]) - 33'(r_cam[i]);
                    end
                    r_state <= S_PSCALE;
                end
                S_PSCALE: begin
                    for (int i = 0; i < 3; i++) begin
                        r_cs[i] <= r_c[i][32] ? -$signed(smag[i][31:0])
                                              : $signed(smag[i][31:0]);
                    end
                    r_acc <= '0;
                    r_idx <= '0;
                    if (smag[0] == '0 && smag[1] == '0) begin
                        r_state <= S_CSET;
                    end else begin
                        r_state <= S_PSQ;
                    end
                end
                S_PSQ: begin
                    r_prod  <= mul_p;
                    r_state <= S_PACC;
                end
                S_PACC: begin
                    r_acc <= r_acc + r_prod;
                    if (r_idx == 3'd1) begin
                        r_sumh <= r_acc + r_prod;
                    end
                    if (r_idx == 3'd2) begin
                        r_sqsel <= SQ_LH;
                        r_state <= S_SQ_GO;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_PSQ;
                    end
                end
                S_SQ_GO: begin
                    r_state <= S_SQ_W;
                end
                S_SQ_W: begin
                    if (sq_done) begin
                        unique case (r_sqsel)
                            SQ_LH: begin
                                r_lh    <= sq_root;
                                r_sqsel <= SQ_LC;
                                r_state <= S_SQ_GO;
                            end
                            SQ_LC: begin
                                r_lc    <= sq_root;
                                r_idx   <= '0;
                                r_state <= S_DMUL;
                            end
                            default: begin
                                r_tess  <= (sq_root > 32'(RES_MAX)) ? RES_MAX : sq_root[11:0];
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DMUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_DV_GO;
                end
                S_DV_GO: begin
                    r_nneg  <= num_s[63];
                    r_state <= S_DV_W;
                end
                S_DV_W: begin
                    if (div_done) begin
                        if (r_idx == DV_TESS) begin
                            r_tq    <= div_quo;
                            r_sqsel <= SQ_TESS;
                            r_state <= S_SQ_GO;
                        end else begin
                            r_q[r_idx] <= r_nneg ? -$signed(div_quo) : $signed(div_quo);
                            if (r_idx == 3'd4) begin
                                r_idx   <= '0;
                                r_state <= S_PM1;
                            end else begin
                                r_idx   <= r_idx + 1'b1;
                                r_state <= S_DMUL;
                            end
                        end
                    end
                end
                S_PM1: begin
                    r_prod  <= mul_p;
                    r_state <= S_PM2;
                end
                S_PM2: begin
                    r_acc   <= r_prod;
                    r_prod  <= mul_p;
                    r_state <= S_PM3;
                end
                S_PM3: begin
                    r_acc   <= r_acc + r_prod;
                    r_state <= S_PM4;
                end
                S_PM4: begin
                    r_acc   <= rnd30(r_acc);
                    r_state <= S_PM5;
                end
                S_PM5: begin
                    r_look[r_idx[1:0]] <= sat32($signed(r_acc[33:0]) + 34'(r_look[r_idx[1:0]]));
                    if (r_idx == 3'd2) begin
                        r_idx   <= '0;
                        r_state <= S_CSET;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_PM1;
                    end
                end
                S_CSET: begin
                    r_cx    <= GAIN_Q30;
                    r_cy    <= '0;
                    r_cz    <= 34'($signed(cs_a));
                    r_cflip <= cs_t[31];
                    r_it    <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (!r_cz[33]) begin
                        r_cx <= r_cx - cy_s;
                        r_cy <= r_cy + cx_s;
                        r_cz <= r_cz - c_atn;
                    end else begin
                        r_cx <= r_cx + cy_s;
                        r_cy <= r_cy - cx_s;
                        r_cz <= r_cz + c_atn;
                    end
                    if (r_it == CORD_LAST) begin
                        r_state <= S_CSTO;
                    end else begin
                        r_it <= r_it + 1'b1;
                    end
                end
                S_CSTO: begin
                    r_trig[{r_idx[0], 1'b0}] <= r_cflip ? -r_cx[31:0] : r_cx[31:0];
                    r_trig[{r_idx[0], 1'b1}] <= r_cflip ? -r_cy[31:0] : r_cy[31:0];
                    if (r_idx[0]) begin
                        r_idx   <= '0;
                        r_state <= S_HMUL;
                    end else begin
                        r_idx   <= 3'd1;
                        r_state <= S_CSET;
                    end
                end
                S_HMUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_HRND;
                end
                S_HRND: begin
                    r_h[r_idx[0]] <= 32'(rnd30(r_prod));
                    if (r_idx[0]) begin
                        r_idx   <= '0;
                        r_state <= S_CMUL;
                    end else begin
                        r_idx   <= 3'd1;
                        r_state <= S_HMUL;
                    end
                end
                S_CMUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_CRND;
                end
                S_CRND: begin
                    r_acc   <= rnd30(r_prod);
                    r_state <= S_CUPD;
                end
                S_CUPD: begin
                    r_cam[r_idx[1:0]] <= sat32($signed(r_acc[33:0]) + 34'(r_look[r_idx[1:0]]));
                    if (r_idx == 3'd2) begin
                        r_state <= r_emit ? S_TESS : S_IDLE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_CMUL;
                    end
                end
                S_TESS: begin
                    if (r_dist == '0) begin
                        r_tess  <= RES_MAX;
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= DV_TESS;
                        r_state <= S_DV_GO;
                    end
                end
                S_DONE: begin
                    if (load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.cam_pos_x       <= r_cam[0];
            r_out.cam_pos_y       <= r_cam[1];
            r_out.cam_pos_z       <= r_cam[2];
            r_out.target_x        <= r_look[0];
            r_out.target_y        <= r_look[1];
            r_out.target_z        <= r_look[2];
            r_out.distance_out    <= r_dist;
            r_out.flipped         <= r_flag;
            r_out.retessellate    <= r_retess;
            r_out.tess_resolution <= r_tess;
        end
    end

    a_polar_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_polar <= 16'h8000)
        else $error("polar angle beyond half turn");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DV_W))
        else $error("quotient returned outside wait state");

    a_sqrt_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == S_SQ_W))
        else $error("root returned outside wait state");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !pop) |=> (r_out_valid && $stable(r_out)))
        else $error("waiting result lost or changed");

endmodule
